@@ rtl/d2e_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// d2e_pkg
// Types, constants and table functions for the date to epoch seconds converter.
// ----------------------------------------------------------------------------
package d2e_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int MDAY_W  = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int EPOCH_W = 40;
	localparam int YDAY_W  = 9;

	localparam int DAYS_W  = 24; // signed day count, covers years 0 .. 16383
	localparam int TOD_W   = 17; // seconds within the day from raw time fields

	localparam int FIRST_YEAR   = 1900;
	localparam int EPOCH_OFFSET = 70;
	localparam int DAYS_PER_YEAR = 365;
	localparam int SECS_PER_DAY  = 86400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN  = 60;
	localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd11;
	localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd1;

	// floor(y / 25) for y < 4096 as a multiply by a scaled reciprocal
	localparam int RECIP_SHIFT = 17;
	localparam logic [12:0] RECIP25 = 13'd5243;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [MDAY_W-1:0]  day_of_month;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
	} date_t;

	typedef struct packed {
		logic signed [EPOCH_W-1:0] epoch_seconds;
		logic [YDAY_W-1:0]         day_of_year;
		logic                      invalid;
	} result_t;

	function automatic logic [7:0] div25(input logic [11:0] y);
		logic [24:0] p;
		p = 25'(y) * 25'(RECIP25);
		return p[24:RECIP_SHIFT];
	endfunction

	function automatic logic [YDAY_W-1:0] cum_days(input logic leap,
		input logic [MONTH_W-1:0] mon);
		logic [YDAY_W-1:0] d;
		case (mon)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		// leap day shifts every month after february
		if (leap && mon > FEBRUARY && mon <= LAST_MONTH)
			d = d + 9'd1;
		return d;
	endfunction

	function automatic logic [MDAY_W-1:0] month_len(input logic leap,
		input logic [MONTH_W-1:0] mon);
		logic [MDAY_W-1:0] n;
		case (mon)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: n = 5'd31;
			4'd3, 4'd5, 4'd8, 4'd10:                   n = 5'd30;
			4'd1:    n = leap ? 5'd29 : 5'd28;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

@@ rtl/date_to_epoch_seconds.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// date_to_epoch_seconds
// Converts a broken-down UTC date and time into signed POSIX seconds since
// 1970-01-01 with day of year and an invalid-date flag.
// ----------------------------------------------------------------------------
// done and the result are registered after the input, quotient and day count stages
// throughput: one transaction per cycle; busy is never raised
// the rate is set by the four-register pipeline: input, quotients, day count,
// and the day count times 86400 multiply feeding the result register
// reset clears the valid bits of every stage; results cannot be stalled
module date_to_epoch_seconds
	import d2e_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire date_t   date,
	output logic         done,
	output result_t      result
);

	// stage 1: input register
	logic  valid_s1;
	date_t date_s1;

	// stage 2: year quotients and base day count
	logic                     valid_s2;
	date_t                    date_s2;
	logic                     year_ok_s2;
	logic signed [DAYS_W-1:0] base_s2;
	logic signed [15:0]       q4_s2;
	logic [7:0]               q100_s2;
	logic [7:0]               q400_s2;
	logic [7:0]               yq100_s2;
	logic [7:0]               yq400_s2;

	// stage 3: day count since the epoch
	logic                     valid_s3;
	logic                     invalid_s3;
	logic [YDAY_W-1:0]        yday_s3;
	logic signed [DAYS_W-1:0] days_s3;
	logic [HOUR_W-1:0]        hour_s3;
	logic [MIN_W-1:0]         minute_s3;
	logic [SEC_W-1:0]         second_s3;

	logic    done_q;
	result_t result_q;

	// ---------------- stage 1 -> 2 logic ----------------
	logic signed [15:0]       ty_c;
	logic signed [15:0]       a_c;
	logic signed [15:0]       b_c;
	logic signed [15:0]       c_c;
	logic signed [15:0]       q4_c;
	logic [7:0]               q100_c;
	logic signed [DAYS_W-1:0] base_c;

	always_comb begin
		ty_c = $signed({2'b00, date_s1.year}) - 16'(FIRST_YEAR);
		a_c  = ty_c - 16'sd69;
		b_c  = ty_c - 16'sd1;
		c_c  = ty_c + 16'sd299;
		// truncate toward zero for a negative dividend
		q4_c = (a_c >>> 2) + 16'((a_c[15] && (a_c[1:0] != 2'b00)) ? 1 : 0);
		q100_c = b_c[15] ? 8'd0 : div25(b_c[13:2]);
		base_c = DAYS_W'(ty_c - 16'(EPOCH_OFFSET)) * DAYS_W'(DAYS_PER_YEAR);
	end

	// ---------------- stage 2 -> 3 logic ----------------
	logic                     div4_c;
	logic                     div100_c;
	logic                     div400_c;
	logic                     leap_c;
	logic                     invalid_c;
	logic [YDAY_W-1:0]        yday_c;
	logic signed [DAYS_W-1:0] days_c;
	logic [12:0]              chk100_c;
	logic [12:0]              chk400_c;

	always_comb begin
		chk100_c = 13'(yq100_s2) * 13'd25;
		chk400_c = 13'(yq400_s2) * 13'd25;
		div4_c   = (date_s2.year[1:0] == 2'b00);
		div100_c = div4_c && (chk100_c == 13'(date_s2.year[13:2]));
		div400_c = (date_s2.year[3:0] == 4'b0000) &&
			(chk400_c == 13'(date_s2.year[13:4]));
		leap_c   = (div4_c && !div100_c) || div400_c;
		invalid_c = !year_ok_s2 || (date_s2.month > LAST_MONTH) ||
			(date_s2.day_of_month == '0) ||
			(date_s2.day_of_month > month_len(leap_c, date_s2.month));
		yday_c = cum_days(leap_c, date_s2.month) + YDAY_W'(date_s2.day_of_month)
			- YDAY_W'(1);
		days_c = base_s2 + DAYS_W'(q4_s2) - DAYS_W'(q100_s2) + DAYS_W'(q400_s2)
			+ DAYS_W'(yday_c);
	end

	// ---------------- stage 3 -> result logic ----------------
	logic signed [EPOCH_W-1:0] day_secs_c;
	logic [TOD_W-1:0]          tod_c;
	logic [EPOCH_W-1:0]        secs_c;

	always_comb begin
		day_secs_c = EPOCH_W'(days_s3) * EPOCH_W'(SECS_PER_DAY);
		tod_c = TOD_W'(TOD_W'(hour_s3) * TOD_W'(SECS_PER_HOUR))
			+ TOD_W'(TOD_W'(minute_s3) * TOD_W'(SECS_PER_MIN))
			+ TOD_W'(second_s3);
		secs_c = day_secs_c + EPOCH_W'(tod_c);
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		date_s1 <= date;

		date_s2    <= date_s1;
		year_ok_s2 <= (date_s1.year >= YEAR_W'(FIRST_YEAR));
		base_s2    <= base_c;
		q4_s2      <= q4_c;
		q100_s2    <= q100_c;
		q400_s2    <= div25({2'b00, c_c[13:4]});
		yq100_s2   <= div25(date_s1.year[13:2]);
		yq400_s2   <= div25({2'b00, date_s1.year[13:4]});

		invalid_s3 <= invalid_c;
		yday_s3    <= yday_c;
		days_s3    <= days_c;
		hour_s3    <= date_s2.hour;
		minute_s3  <= date_s2.minute;
		second_s3  <= date_s2.second;

		result_q.invalid       <= invalid_s3;
		result_q.epoch_seconds <= invalid_s3 ? '0 : $signed(secs_c);
		result_q.day_of_year   <= invalid_s3 ? '0 : yday_s3;
	end

	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = result_q;

	// ---------------- assertions ----------------
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result without a matching transaction");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.invalid |-> (result.epoch_seconds == '0) &&
			(result.day_of_year == '0))
		else $error("invalid result carries nonzero fields");

	a_yday_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.invalid |-> result.day_of_year <= YDAY_W'(365))
		else $error("day of year out of range");

endmodule
`default_nettype wire
